### rtl/gamr_pkg.sv
// Shared types, codes and neighbor tables for the grid route planner.
// Depends on nothing; every other file imports it.
`default_nettype none

package gamr_pkg;

	localparam int COST_W = 17;
	localparam int TIME_W = 15;
	localparam int NB_COUNT4 = 4;
	localparam int NB_COUNT8 = 8;

	localparam logic [0:0] REG_ADJACENCY = 1'd0;
	localparam logic [0:0] REG_PENALTY = 1'd1;
	localparam logic [7:0] PENALTY_RESET = 8'd100;

	typedef enum logic [1:0] {
		CMD_PLAN  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CELL  = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  start_row;
		logic [3:0]  start_col;
		logic [3:0]  end_row;
		logic [3:0]  end_col;
		logic [14:0] depart_time;
		logic [7:0]  path_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] path_length;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SWEEP, S_SWEEP_END, S_INIT, S_POP, S_SCAN, S_SCAN_END,
		S_POP_RD, S_POP_WR, S_EXPAND, S_NB_ISSUE, S_NB_EVAL, S_NB_UPD, S_FINISH,
		S_W1_CHK, S_W1_WAIT, S_W2_INIT, S_W2_ISSUE, S_W2_WAIT, S_RESULT
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    clr_path;
		logic    set_path;
		logic    sweep_start;
		logic    sweep_step;
		logic    init;
		logic    scan_start;
		logic    scan_step;
		logic    pop_rd;
		logic    pop_wr;
		logic    load_base;
		logic    walk_init;
		logic    nb_issue;
		logic    nb_eval;
		logic    nb_push;
		logic    finish;
		logic    walk_rd;
		logic    w1_step;
		logic    w2_init;
		logic    w2_write;
		logic    w2_next;
		logic    path_rd;
		logic    clear_occ;
		logic    load_result;
		logic    res_cells;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       bad_cell;
		logic       idx_ok;
		logic       sweep_last;
		logic       heap_empty;
		logic       scan_last;
		logic       cur_is_end;
		logic       nb_done;
		logic       nb_oob;
		logic       upd_need;
		logic       heap_full;
		logic       cur_is_start;
		logic       walk_full;
		logic       walk_cv;
		logic       k_zero;
	} dp_stat_t;

	typedef struct packed {
		logic dec_r;
		logic inc_r;
		logic dec_c;
		logic inc_c;
	} delta_t;

	// Neighbor order: four-way is down, up, right, left; eight-way is row major.
	function automatic delta_t nb_delta(input logic mode, input logic [2:0] d);
		delta_t r;
		r = '0;
		if (mode) begin
			unique case (d)
				3'd0: r = '{dec_r: 1'b1, inc_r: 1'b0, dec_c: 1'b1, inc_c: 1'b0};
				3'd1: r = '{dec_r: 1'b1, inc_r: 1'b0, dec_c: 1'b0, inc_c: 1'b0};
				3'd2: r = '{dec_r: 1'b1, inc_r: 1'b0, dec_c: 1'b0, inc_c: 1'b1};
				3'd3: r = '{dec_r: 1'b0, inc_r: 1'b0, dec_c: 1'b1, inc_c: 1'b0};
				3'd4: r = '{dec_r: 1'b0, inc_r: 1'b0, dec_c: 1'b0, inc_c: 1'b1};
				3'd5: r = '{dec_r: 1'b0, inc_r: 1'b1, dec_c: 1'b1, inc_c: 1'b0};
				3'd6: r = '{dec_r: 1'b0, inc_r: 1'b1, dec_c: 1'b0, inc_c: 1'b0};
				default: r = '{dec_r: 1'b0, inc_r: 1'b1, dec_c: 1'b0, inc_c: 1'b1};
			endcase
		end else begin
			unique case (d[1:0])
				2'd0: r = '{dec_r: 1'b0, inc_r: 1'b1, dec_c: 1'b0, inc_c: 1'b0};
				2'd1: r = '{dec_r: 1'b1, inc_r: 1'b0, dec_c: 1'b0, inc_c: 1'b0};
				2'd2: r = '{dec_r: 1'b0, inc_r: 1'b0, dec_c: 1'b0, inc_c: 1'b1};
				default: r = '{dec_r: 1'b0, inc_r: 1'b0, dec_c: 1'b1, inc_c: 1'b0};
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/gamr_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on gamr_pkg for the payload types.
`default_nettype none

interface gamr_req_if import gamr_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gamr_rsp_if import gamr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/gamr_ctrl.sv
// Sequencing state machine for plan, read and clear commands.
// Depends on gamr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module gamr_ctrl import gamr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t  state_q, state_d;
	status_t res_status_q, res_status_d;
	logic    res_cells_q, res_cells_d;
	logic    out_valid_q;
	logic    load;

	assign load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_status_q <= ST_OK;
			res_cells_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_status_q <= res_status_d;
			res_cells_q <= res_cells_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		res_status_d = res_status_q;
		res_cells_d = res_cells_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_status_d = ST_OK;
				res_cells_d = 1'b0;
				state_d = S_RESULT;
				unique case (stat.cmd)
					CMD_PLAN: begin
						if (stat.bad_cell) begin
							res_status_d = ST_BAD_CELL;
						end else begin
							state_d = S_SWEEP;
						end
					end
					CMD_READ: begin
						if (stat.idx_ok) begin
							res_cells_d = 1'b1;
						end else begin
							res_status_d = ST_BAD_INDEX;
						end
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_SWEEP: begin
				if (stat.sweep_last) begin
					state_d = S_SWEEP_END;
				end
			end
			S_SWEEP_END: state_d = S_INIT;
			S_INIT: state_d = S_POP;
			S_POP: begin
				if (stat.heap_empty) begin
					res_status_d = ST_OVERFLOW;
					state_d = S_RESULT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_POP_RD;
			S_POP_RD: state_d = S_POP_WR;
			S_POP_WR: state_d = S_EXPAND;
			S_EXPAND: state_d = stat.cur_is_end ? S_W1_CHK : S_NB_ISSUE;
			S_NB_ISSUE: begin
				if (stat.nb_done) begin
					state_d = S_FINISH;
				end else if (!stat.nb_oob) begin
					state_d = S_NB_EVAL;
				end
			end
			S_NB_EVAL: state_d = S_NB_UPD;
			S_NB_UPD: begin
				if (stat.upd_need && stat.heap_full) begin
					res_status_d = ST_OVERFLOW;
					state_d = S_RESULT;
				end else begin
					state_d = S_NB_ISSUE;
				end
			end
			S_FINISH: state_d = S_POP;
			S_W1_CHK: begin
				if (stat.cur_is_start) begin
					state_d = S_W2_INIT;
				end else if (stat.walk_full) begin
					res_status_d = ST_OVERFLOW;
					state_d = S_RESULT;
				end else begin
					state_d = S_W1_WAIT;
				end
			end
			S_W1_WAIT: begin
				if (!stat.walk_cv) begin
					res_status_d = ST_OVERFLOW;
					state_d = S_RESULT;
				end else begin
					state_d = S_W1_CHK;
				end
			end
			S_W2_INIT: state_d = S_W2_ISSUE;
			S_W2_ISSUE: state_d = S_W2_WAIT;
			S_W2_WAIT: begin
				if (stat.k_zero) begin
					res_status_d = ST_OK;
					state_d = S_RESULT;
				end else begin
					state_d = S_W2_ISSUE;
				end
			end
			S_RESULT: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = res_status_q;
		cmd.res_cells = res_cells_q;
		unique case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_DECODE: begin
				if (stat.cmd == CMD_PLAN) begin
					cmd.clr_path = 1'b1;
					cmd.sweep_start = !stat.bad_cell;
				end
				if (stat.cmd == CMD_READ) begin
					cmd.path_rd = stat.idx_ok;
				end
				if (stat.cmd == CMD_CLEAR) begin
					cmd.clear_occ = 1'b1;
				end
			end
			S_SWEEP: cmd.sweep_step = 1'b1;
			S_INIT: cmd.init = 1'b1;
			S_POP: cmd.scan_start = !stat.heap_empty;
			S_SCAN: cmd.scan_step = 1'b1;
			S_POP_RD: cmd.pop_rd = 1'b1;
			S_POP_WR: cmd.pop_wr = 1'b1;
			S_EXPAND: begin
				cmd.load_base = 1'b1;
				cmd.walk_init = stat.cur_is_end;
			end
			S_NB_ISSUE: cmd.nb_issue = !stat.nb_done;
			S_NB_EVAL: cmd.nb_eval = 1'b1;
			S_NB_UPD: cmd.nb_push = stat.upd_need && !stat.heap_full;
			S_FINISH: cmd.finish = 1'b1;
			S_W1_CHK: cmd.walk_rd = !stat.cur_is_start && !stat.walk_full;
			S_W1_WAIT: cmd.w1_step = stat.walk_cv;
			S_W2_INIT: cmd.w2_init = 1'b1;
			S_W2_ISSUE: cmd.w2_write = 1'b1;
			S_W2_WAIT: begin
				cmd.w2_next = 1'b1;
				cmd.set_path = stat.k_zero;
			end
			S_RESULT: cmd.load_result = load;
			default: cmd.latch = 1'b0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/gamr_dp.sv
// Datapath: grid memories, open list scan, neighbor costing and path walk.
// Depends on gamr_pkg; steered by gamr_ctrl through dp_cmd_t.
`default_nettype none

module gamr_dp import gamr_pkg::*; #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16,
	parameter int HEAP_DEPTH = 2048
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	input  wire req_t       req_data,
	output rsp_t            rsp_data,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int CA_W = $clog2(CELLS);
	localparam int HA_W = $clog2(HEAP_DEPTH);
	localparam int HC_W = $clog2(HEAP_DEPTH + 1);
	localparam int PC_W = $clog2(CELLS + 1);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int CLW = $clog2(GRID_COLS);
	localparam int RC_W = RW + CLW;
	localparam int KW = COST_W + RC_W;

	function automatic logic [CA_W-1:0] cell_of(input logic [RW-1:0] r,
		input logic [CLW-1:0] c);
		return CA_W'(32'(r) * GRID_COLS + 32'(c));
	endfunction

	function automatic logic [RW-1:0] rdiff(input logic [RW-1:0] a, input logic [RW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [CLW-1:0] cdiff(input logic [CLW-1:0] a,
		input logic [CLW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	logic [TIME_W-1:0] occ_mem [CELLS];
	logic [COST_W:0]   search_mem [CELLS];
	logic [COST_W:0]   cost_mem [CELLS];
	logic [RC_W-1:0]   parent_mem [CELLS];
	logic [RC_W-1:0]   path_mem [CELLS];
	logic [KW-1:0]     heap_mem [HEAP_DEPTH];

	logic [CELLS-1:0]  occ_valid_q;
	logic              adj_q;
	logic [7:0]        pen_q;
	req_t              req_q;
	rsp_t              rsp_q;

	logic [CA_W-1:0]   sweep_i_q, sweep_a_s1;
	logic              sweep_s1;
	logic              occ_v_s1;
	logic [TIME_W-1:0] occ_rd_s1;

	logic [HC_W-1:0]   heap_count_q;
	logic [HA_W-1:0]   scan_i_q, scan_a_s1;
	logic              scan_s1;
	logic [KW-1:0]     best_key_q;
	logic [HA_W-1:0]   best_idx_q;
	logic              best_ok_q;
	logic [KW-1:0]     heap_rd_q;

	logic [RW-1:0]     cur_r_q, nr_q;
	logic [CLW-1:0]    cur_c_q, nc_q;
	logic [CA_W-1:0]   ncell_q;
	logic [COST_W-1:0] base_q, cost_q, h_q;
	logic [3:0]        nb_d_q;
	logic [COST_W:0]   search_rd_q, cost_rd_q;
	logic [RC_W-1:0]   parent_rd_q, path_rd_q;
	logic [PC_W-1:0]   walk_n_q, walk_k_q, path_count_q;

	logic [RW-1:0]     sr, er, nr_n;
	logic [CLW-1:0]    sc, ec, nc_n;
	logic [CA_W-1:0]   cur_cell, start_cell, best_cell;
	delta_t            dl;
	logic              nb_oob;
	logic [COST_W-1:0] step_cost;
	logic              heap_full;

	assign sr = RW'(req_q.start_row);
	assign sc = CLW'(req_q.start_col);
	assign er = RW'(req_q.end_row);
	assign ec = CLW'(req_q.end_col);
	assign cur_cell = cell_of(cur_r_q, cur_c_q);
	assign start_cell = cell_of(sr, sc);
	assign best_cell = cell_of(best_key_q[RC_W-1:CLW], best_key_q[CLW-1:0]);
	assign heap_full = (heap_count_q == HC_W'(HEAP_DEPTH));

	assign dl = nb_delta(adj_q, nb_d_q[2:0]);
	assign nb_oob = (dl.dec_r && cur_r_q == '0) ||
		(dl.inc_r && cur_r_q == RW'(GRID_ROWS - 1)) ||
		(dl.dec_c && cur_c_q == '0) ||
		(dl.inc_c && cur_c_q == CLW'(GRID_COLS - 1));
	assign nr_n = dl.inc_r ? cur_r_q + 1'b1 : (dl.dec_r ? cur_r_q - 1'b1 : cur_r_q);
	assign nc_n = dl.inc_c ? cur_c_q + 1'b1 : (dl.dec_c ? cur_c_q - 1'b1 : cur_c_q);
	assign step_cost = (search_rd_q[COST_W] && search_rd_q[COST_W-1:0] <= base_q) ?
		COST_W'(pen_q) : COST_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q <= 1'b0;
			pen_q <= PENALTY_RESET;
			occ_valid_q <= '0;
			heap_count_q <= '0;
			path_count_q <= '0;
			sweep_s1 <= 1'b0;
			scan_s1 <= 1'b0;
			best_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ADJACENCY: adj_q <= cfg_data[0];
					REG_PENALTY: pen_q <= cfg_data;
					default: adj_q <= adj_q;
				endcase
			end
			if (cmd.clear_occ) begin
				occ_valid_q <= '0;
			end else if (cmd.w2_write) begin
				occ_valid_q[cur_cell] <= 1'b1;
			end
			if (cmd.init) begin
				heap_count_q <= HC_W'(1);
			end else if (cmd.pop_wr) begin
				heap_count_q <= heap_count_q - 1'b1;
			end else if (cmd.nb_push) begin
				heap_count_q <= heap_count_q + 1'b1;
			end
			if (cmd.clr_path) begin
				path_count_q <= '0;
			end else if (cmd.set_path) begin
				path_count_q <= walk_n_q;
			end
			sweep_s1 <= cmd.sweep_step;
			scan_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				best_ok_q <= 1'b0;
			end else if (scan_s1) begin
				best_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_data;
		end
		if (cmd.sweep_start) begin
			sweep_i_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_i_q <= sweep_i_q + 1'b1;
		end
		sweep_a_s1 <= sweep_i_q;
		occ_v_s1 <= occ_valid_q[sweep_i_q];
		if (cmd.scan_start) begin
			scan_i_q <= '0;
		end else if (cmd.scan_step) begin
			scan_i_q <= scan_i_q + 1'b1;
		end
		scan_a_s1 <= scan_i_q;
		if (scan_s1 && (!best_ok_q || heap_rd_q < best_key_q)) begin
			best_key_q <= heap_rd_q;
			best_idx_q <= scan_a_s1;
		end
		if (cmd.pop_wr) begin
			cur_r_q <= best_key_q[RC_W-1:CLW];
			cur_c_q <= best_key_q[CLW-1:0];
		end else if (cmd.w1_step || cmd.w2_next) begin
			cur_r_q <= parent_rd_q[RC_W-1:CLW];
			cur_c_q <= parent_rd_q[CLW-1:0];
		end else if (cmd.w2_init) begin
			cur_r_q <= er;
			cur_c_q <= ec;
		end
		if (cmd.load_base) begin
			base_q <= cost_rd_q[COST_W-1:0];
			nb_d_q <= '0;
		end else if (cmd.nb_issue) begin
			nb_d_q <= nb_d_q + 1'b1;
		end
		if (cmd.nb_issue && !nb_oob) begin
			nr_q <= nr_n;
			nc_q <= nc_n;
			ncell_q <= cell_of(nr_n, nc_n);
		end
		if (cmd.nb_eval) begin
			cost_q <= base_q + step_cost;
			h_q <= COST_W'(rdiff(nr_q, er)) + COST_W'(cdiff(nc_q, ec));
		end
		if (cmd.walk_init) begin
			walk_n_q <= PC_W'(1);
		end else if (cmd.w1_step) begin
			walk_n_q <= walk_n_q + 1'b1;
		end
		if (cmd.w2_init) begin
			walk_k_q <= walk_n_q;
		end else if (cmd.w2_write) begin
			walk_k_q <= walk_k_q - 1'b1;
		end
		if (cmd.load_result) begin
			rsp_q.status <= cmd.res_status;
			rsp_q.path_length <= 9'(path_count_q);
			rsp_q.cell_row <= cmd.res_cells ? 4'(path_rd_q[RC_W-1:CLW]) : 4'd0;
			rsp_q.cell_col <= cmd.res_cells ? 4'(path_rd_q[CLW-1:0]) : 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.w2_write) begin
			occ_mem[cur_cell] <= req_q.depart_time;
		end
		if (cmd.sweep_step) begin
			occ_rd_s1 <= occ_mem[sweep_i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_s1) begin
			search_mem[sweep_a_s1] <= {occ_v_s1, COST_W'(occ_rd_s1)};
		end else if (cmd.finish) begin
			search_mem[cur_cell] <= {1'b1, base_q};
		end
		if (cmd.nb_issue && !nb_oob) begin
			search_rd_q <= search_mem[cell_of(nr_n, nc_n)];
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_s1) begin
			cost_mem[sweep_a_s1] <= '0;
		end else if (cmd.init) begin
			cost_mem[start_cell] <= {1'b1, COST_W'(0)};
		end else if (cmd.nb_push) begin
			cost_mem[ncell_q] <= {1'b1, cost_q};
		end
		if (cmd.pop_wr) begin
			cost_rd_q <= cost_mem[best_cell];
		end else if (cmd.nb_issue && !nb_oob) begin
			cost_rd_q <= cost_mem[cell_of(nr_n, nc_n)];
		end else if (cmd.walk_rd) begin
			cost_rd_q <= cost_mem[cur_cell];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nb_push) begin
			parent_mem[ncell_q] <= {cur_r_q, cur_c_q};
		end
		if (cmd.walk_rd || cmd.w2_write) begin
			parent_rd_q <= parent_mem[cur_cell];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.w2_write) begin
			path_mem[CA_W'(walk_k_q - 1'b1)] <= {cur_r_q, cur_c_q};
		end
		if (cmd.path_rd) begin
			path_rd_q <= path_mem[CA_W'(req_q.path_index)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			heap_mem[HA_W'(0)] <= {COST_W'(0), sr, sc};
		end else if (cmd.pop_wr) begin
			heap_mem[best_idx_q] <= heap_rd_q;
		end else if (cmd.nb_push) begin
			heap_mem[HA_W'(heap_count_q)] <= {cost_q + h_q, nr_q, nc_q};
		end
		if (cmd.scan_step) begin
			heap_rd_q <= heap_mem[scan_i_q];
		end else if (cmd.pop_rd) begin
			heap_rd_q <= heap_mem[HA_W'(heap_count_q - 1'b1)];
		end
	end

	always_comb begin
		stat.cmd = req_q.cmd;
		stat.bad_cell = (32'(req_q.start_row) >= GRID_ROWS) ||
			(32'(req_q.start_col) >= GRID_COLS) ||
			(32'(req_q.end_row) >= GRID_ROWS) ||
			(32'(req_q.end_col) >= GRID_COLS);
		stat.idx_ok = 32'(req_q.path_index) < 32'(path_count_q);
		stat.sweep_last = (sweep_i_q == CA_W'(CELLS - 1));
		stat.heap_empty = (heap_count_q == '0);
		stat.scan_last = (scan_i_q == HA_W'(heap_count_q - 1'b1));
		stat.cur_is_end = (cur_r_q == er) && (cur_c_q == ec);
		stat.nb_done = adj_q ? (nb_d_q == 4'(NB_COUNT8)) : (nb_d_q == 4'(NB_COUNT4));
		stat.nb_oob = nb_oob;
		stat.upd_need = !cost_rd_q[COST_W] || (cost_q < cost_rd_q[COST_W-1:0]);
		stat.heap_full = heap_full;
		stat.cur_is_start = (cur_r_q == sr) && (cur_c_q == sc);
		stat.walk_full = (walk_n_q >= PC_W'(CELLS));
		stat.walk_cv = cost_rd_q[COST_W];
		stat.k_zero = (walk_k_q == '0);
	end

	assign rsp_data = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		heap_count_q <= HC_W'(HEAP_DEPTH))
		else $error("open list count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nb_push |-> !heap_full)
		else $error("push into a full open list");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_wr |-> heap_count_q != '0)
		else $error("pop from an empty open list");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w2_write |-> walk_k_q != '0)
		else $error("path write below index zero");

endmodule

`default_nettype wire

### rtl/grid_astar_multi_route_planner.sv
// Grid route planner top level: controller, datapath and channel glue.
// Depends on gamr_pkg, gamr_if, gamr_ctrl and gamr_dp.
// Read, clear and rejected plans go straight to a result. A plan sweeps the working
// grid, then per expansion does a linear open-list scan and visits each neighbor on
// the grid, and at the end walks the path back cell by cell.
// Asynchronous reset empties occupancy, the open list and the path at once.
`default_nettype none

module grid_astar_multi_route_planner import gamr_pkg::*; #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16,
	parameter int HEAP_DEPTH = 2048
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	gamr_req_if.sink        req,
	gamr_rsp_if.source      rsp,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gamr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gamr_dp #(
		.GRID_ROWS  (GRID_ROWS),
		.GRID_COLS  (GRID_COLS),
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req.data),
		.rsp_data  (rsp.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
